// ----- rtl/lzp_pkg.sv -----
`default_nettype none
package lzp_pkg;

    localparam int TABLE_BITS  = 16;
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;
    localparam int LITERAL_MAX = 62;
    localparam int MATCH_MAX   = 65535;
    localparam int HASH_SHIFT  = 5;

    // Count of buffered literals (0..LITERAL_MAX) and index into the literal store.
    localparam int LIT_W     = $clog2(LITERAL_MAX + 1);
    localparam int LIT_IDX_W = (LITERAL_MAX > 1) ? $clog2(LITERAL_MAX) : 1;

    localparam logic [4:0] HASH_BITS_RESET = 5'd16;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

    // Token kinds on the output channel.
    localparam logic [1:0] KIND_MATCH   = 2'd0;
    localparam logic [1:0] KIND_LITHDR  = 2'd1;
    localparam logic [1:0] KIND_LITBYTE = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // Commands passed from the front to the back.
    localparam logic [1:0] CMD_MATCH  = 2'd0;
    localparam logic [1:0] CMD_LITRUN = 2'd1;
    localparam logic [1:0] CMD_END    = 2'd2;
    localparam logic [1:0] CMD_PUT    = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] len;
        logic [7:0]  value;
        logic        last;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] len;
        logic [7:0]  value;
        logic        last;
    } t_token;

endpackage
`default_nettype wire

// ----- rtl/lzp_front.sv -----
`default_nettype none
module lzp_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [4:0]   i_cfg_wdata,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic         i_command,
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_full,
    output logic              o_push,
    output lzp_pkg::t_cmd     o_cmd
);

    localparam logic [1:0] F_CLEAR = 2'd0;
    localparam logic [1:0] F_IDLE  = 2'd1;
    localparam logic [1:0] F_LOOK  = 2'd2;
    localparam logic [1:0] F_ISSUE = 2'd3;

    localparam int TB = lzp_pkg::TABLE_BITS;

    localparam logic [4:0] HASH_BITS_RESET_C = lzp_pkg::HASH_BITS_RESET;

    logic [7:0] mem [0:lzp_pkg::TABLE_DEPTH-1];

    logic [1:0]          r_st;
    logic [TB-1:0]       r_clr;
    logic [TB-1:0]       r_hash;
    logic [15:0]         r_match;
    logic [lzp_pkg::LIT_W-1:0] r_lit;
    logic [4:0]          r_hb;
    logic                r_cmd_in;
    logic [7:0]          r_byte;
    logic [TB-1:0]       r_tidx;
    logic [7:0]          r_tdata;
    lzp_pkg::t_cmd       r_q [0:2];
    logic [1:0]          r_qcnt;
    logic [1:0]          r_qidx;
    logic                r_flush;

    logic [4:0]          hb_eff;
    logic [TB-1:0]       mask;
    logic [TB-1:0]       ones;
    logic                accept;
    logic                last_slot;
    logic                hit;
    logic [16:0]         match_inc;
    logic                match_full;
    logic [lzp_pkg::LIT_W-1:0] lit_inc;
    logic                lit_full;
    logic [TB-1:0]       hash_next;
    lzp_pkg::t_cmd       n_list [0:2];
    logic [1:0]          n_cnt;
    logic [15:0]         n_match;
    logic [lzp_pkg::LIT_W-1:0] n_lit;
    logic                tab_we;
    logic [TB-1:0]       tab_waddr;
    logic [7:0]          tab_wdata;

    assign ones   = '1;
    assign hb_eff = (r_hb > 5'(TB)) ? 5'(TB) : r_hb;
    assign mask   = ~(ones << hb_eff);

    assign last_slot = (r_qidx == (r_qcnt - 2'd1));
    assign o_ready   = (r_st == F_IDLE) ||
                       ((r_st == F_ISSUE) && !i_full && last_slot && !r_flush);
    assign accept    = i_valid && o_ready;

    assign o_push = (r_st == F_ISSUE) && !i_full;
    assign o_cmd  = r_q[r_qidx];

    assign hit        = (r_tdata == r_byte);
    assign match_inc  = {1'b0, r_match} + 17'd1;
    assign match_full = (match_inc >= 17'(lzp_pkg::MATCH_MAX));
    assign lit_inc    = r_lit + 1'b1;
    assign lit_full   = (lit_inc >= lzp_pkg::LIT_W'(lzp_pkg::LITERAL_MAX));
    assign hash_next  = ((r_hash << lzp_pkg::HASH_SHIFT) + {{(TB-8){1'b0}}, r_byte}) & mask;

    // Build the list of commands for the current word, in emission order.
    always_comb begin
        n_list[0] = '0;
        n_list[1] = '0;
        n_list[2] = '0;
        n_cnt     = 2'd0;
        n_match   = r_match;
        n_lit     = r_lit;
        if (r_cmd_in) begin
            if (r_match != 16'd0) begin
                n_list[n_cnt] = '{op: lzp_pkg::CMD_MATCH, len: r_match, value: 8'd0, last: 1'b0};
                n_cnt = n_cnt + 2'd1;
            end
            if (r_lit != '0) begin
                n_list[n_cnt] = '{op: lzp_pkg::CMD_LITRUN, len: 16'(r_lit), value: 8'd0,
                                  last: 1'b0};
                n_cnt = n_cnt + 2'd1;
            end
            n_list[n_cnt] = '{op: lzp_pkg::CMD_END, len: 16'd0, value: 8'd0, last: 1'b1};
            n_cnt   = n_cnt + 2'd1;
            n_match = 16'd0;
            n_lit   = '0;
        end else if (hit) begin
            if (r_lit != '0) begin
                n_list[n_cnt] = '{op: lzp_pkg::CMD_LITRUN, len: 16'(r_lit), value: 8'd0,
                                  last: !match_full};
                n_cnt = n_cnt + 2'd1;
            end
            if (match_full) begin
                n_list[n_cnt] = '{op: lzp_pkg::CMD_MATCH, len: 16'(lzp_pkg::MATCH_MAX),
                                  value: 8'd0, last: 1'b1};
                n_cnt   = n_cnt + 2'd1;
                n_match = 16'd0;
            end else begin
                n_match = match_inc[15:0];
            end
            n_lit = '0;
        end else begin
            if (r_match != 16'd0) begin
                n_list[n_cnt] = '{op: lzp_pkg::CMD_MATCH, len: r_match, value: 8'd0,
                                  last: !lit_full};
                n_cnt = n_cnt + 2'd1;
            end
            n_list[n_cnt] = '{op: lzp_pkg::CMD_PUT, len: 16'd0, value: r_byte, last: 1'b0};
            n_cnt = n_cnt + 2'd1;
            if (lit_full) begin
                n_list[n_cnt] = '{op: lzp_pkg::CMD_LITRUN, len: 16'(lzp_pkg::LITERAL_MAX),
                                  value: 8'd0, last: 1'b1};
                n_cnt = n_cnt + 2'd1;
                n_lit = '0;
            end else begin
                n_lit = lit_inc;
            end
            n_match = 16'd0;
        end
    end

    assign tab_we    = (r_st == F_CLEAR) || ((r_st == F_LOOK) && !r_cmd_in && !hit);
    assign tab_waddr = (r_st == F_CLEAR) ? r_clr : r_tidx;
    assign tab_wdata = (r_st == F_CLEAR) ? 8'd0 : r_byte;

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            mem[tab_waddr] <= tab_wdata;
        end
        if (accept) begin
            r_tdata <= mem[r_hash & mask];
        end
    end

    // Payload captured with the word; no reset needed.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd_in <= i_command;
            r_byte   <= i_byte;
            r_tidx   <= r_hash & mask;
        end
        if (r_st == F_LOOK) begin
            r_q[0] <= n_list[0];
            r_q[1] <= n_list[1];
            r_q[2] <= n_list[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= F_CLEAR;
            r_clr   <= '0;
            r_hash  <= '0;
            r_match <= 16'd0;
            r_lit   <= '0;
            r_hb    <= HASH_BITS_RESET_C;
            r_qcnt  <= 2'd0;
            r_qidx  <= 2'd0;
            r_flush <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hb <= i_cfg_wdata;
            end
            case (r_st)
                F_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ones) begin
                        r_st <= F_IDLE;
                    end
                end
                F_IDLE: begin
                    if (accept) begin
                        r_st <= F_LOOK;
                    end
                end
                F_LOOK: begin
                    r_match <= n_match;
                    r_lit   <= n_lit;
                    r_hash  <= r_cmd_in ? '0 : hash_next;
                    r_flush <= r_cmd_in;
                    r_qcnt  <= n_cnt;
                    r_qidx  <= 2'd0;
                    r_st    <= (n_cnt == 2'd0) ? F_IDLE : F_ISSUE;
                end
                F_ISSUE: begin
                    if (o_push) begin
                        if (last_slot) begin
                            if (r_flush) begin
                                r_st <= F_CLEAR;
                            end else if (accept) begin
                                r_st <= F_LOOK;
                            end else begin
                                r_st <= F_IDLE;
                            end
                        end else begin
                            r_qidx <= r_qidx + 2'd1;
                        end
                    end
                end
                default: r_st <= F_CLEAR;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lzp_cmdq.sv -----
`default_nettype none
module lzp_cmdq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lzp_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output lzp_pkg::t_cmd      o_data,
    output logic               o_empty
);

    localparam int PW = lzp_pkg::CMDQ_PTR_W;

    lzp_pkg::t_cmd r_ent [0:lzp_pkg::CMDQ_DEPTH-1];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == (PW+1)'(lzp_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_ent[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- rtl/lzp_back.sv -----
`default_nettype none
module lzp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire lzp_pkg::t_cmd i_cmd,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_tvalid,
    input  wire logic          i_tready,
    output logic [23:0]        o_tdata,
    output logic [1:0]         o_tuser,
    output logic               o_tlast
);

    localparam logic B_IDLE = 1'b0;
    localparam logic B_BYTE = 1'b1;

    localparam int LW = lzp_pkg::LIT_W;
    localparam int IW = lzp_pkg::LIT_IDX_W;

    logic [7:0] store [0:lzp_pkg::LITERAL_MAX-1];

    logic            r_st;
    logic            r_ov;
    lzp_pkg::t_token r_tok;
    logic [LW-1:0]   r_left;
    logic [IW-1:0]   r_ri;
    logic [IW-1:0]   r_wp;
    logic            r_lastf;
    logic [7:0]      r_rdata;

    logic            n_st;
    logic            n_ov;
    lzp_pkg::t_token n_tok;
    logic [LW-1:0]   n_left;
    logic [IW-1:0]   n_ri;
    logic [IW-1:0]   n_wp;
    logic            n_lastf;
    logic            out_free;
    logic            st_we;
    logic            st_re;
    logic [IW-1:0]   st_raddr;

    assign out_free = !r_ov || i_tready;

    always_comb begin
        n_st     = r_st;
        n_ov     = r_ov && !i_tready;
        n_tok    = r_tok;
        n_left   = r_left;
        n_ri     = r_ri;
        n_wp     = r_wp;
        n_lastf  = r_lastf;
        o_pop    = 1'b0;
        st_we    = 1'b0;
        st_re    = 1'b0;
        st_raddr = '0;
        case (r_st)
            B_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.op)
                        lzp_pkg::CMD_PUT: begin
                            st_we = 1'b1;
                            n_wp  = r_wp + 1'b1;
                            o_pop = 1'b1;
                        end
                        lzp_pkg::CMD_MATCH: begin
                            if (out_free) begin
                                n_tok = '{kind: lzp_pkg::KIND_MATCH, len: i_cmd.len,
                                          value: 8'd0, last: i_cmd.last};
                                n_ov  = 1'b1;
                                o_pop = 1'b1;
                            end
                        end
                        lzp_pkg::CMD_LITRUN: begin
                            if (out_free) begin
                                n_tok   = '{kind: lzp_pkg::KIND_LITHDR, len: i_cmd.len,
                                            value: 8'd0, last: 1'b0};
                                n_ov    = 1'b1;
                                o_pop   = 1'b1;
                                n_left  = i_cmd.len[LW-1:0];
                                n_ri    = '0;
                                n_lastf = i_cmd.last;
                                // Fetch the first byte while the header goes out.
                                st_re   = 1'b1;
                                n_st    = B_BYTE;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                n_tok = '{kind: lzp_pkg::KIND_END, len: 16'd0,
                                          value: 8'd0, last: i_cmd.last};
                                n_ov  = 1'b1;
                                o_pop = 1'b1;
                            end
                        end
                    endcase
                end
            end
            default: begin
                if (out_free) begin
                    n_tok = '{kind: lzp_pkg::KIND_LITBYTE, len: 16'd0, value: r_rdata,
                              last: r_lastf && (r_left == LW'(1))};
                    n_ov  = 1'b1;
                    if (r_left == LW'(1)) begin
                        n_wp = '0;
                        n_st = B_IDLE;
                    end else begin
                        st_re    = 1'b1;
                        st_raddr = r_ri + 1'b1;
                        n_ri     = r_ri + 1'b1;
                        n_left   = r_left - 1'b1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            store[r_wp] <= i_cmd.value;
        end
        if (st_re) begin
            r_rdata <= store[st_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= B_IDLE;
            r_ov    <= 1'b0;
            r_left  <= '0;
            r_ri    <= '0;
            r_wp    <= '0;
            r_lastf <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_ov    <= n_ov;
            r_left  <= n_left;
            r_ri    <= n_ri;
            r_wp    <= n_wp;
            r_lastf <= n_lastf;
        end
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = {r_tok.value, r_tok.len};
    assign o_tuser  = r_tok.kind;
    assign o_tlast  = r_tok.last;

endmodule
`default_nettype wire

// ----- rtl/lzp_predictor_encoder.sv -----
// Predictor byte encoder with run tokens.
// Input words arrive on s_axis: tdata carries the source byte, tuser is the
// command (0 = data byte, 1 = end of stream flush). Each data byte is checked
// against the byte predicted for the current context hash; output words on
// m_axis carry match-run headers, literal-run headers with their bytes, and
// an end marker. tlast marks the final token caused by one input word.
// The front handles one word at a time: a registered table read, then a step
// that updates state and builds the word's commands, which are then queued one
// by one; the next word is taken no earlier than the last of them is queued.
// The back emits one token per cycle at most, and none while the receiver
// stalls; a literal run goes out as its header, then its bytes.
// After reset, and after every flush, the 65536-entry prediction table is
// cleared one entry per cycle and s_axis_tready stays low; configuration
// writes are taken at any time.
// When the receiver stalls, the output register holds its word, the command
// queue fills, and the front then holds s_axis_tready low. The user writes hash_bits
// via i_cfg_we / i_cfg_wdata while the block is idle; the block does not enforce it.
`default_nettype none
module lzp_predictor_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,    // hash_bits
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [15:0] run_length, [23:16] literal_value
    output logic [1:0]       m_axis_tuser,   // [1:0] token_kind
    output logic             m_axis_tlast    // last
);

    logic          q_full;
    logic          q_empty;
    logic          q_push;
    logic          q_pop;
    lzp_pkg::t_cmd q_in;
    lzp_pkg::t_cmd q_out;

    lzp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_command   (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_full      (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    lzp_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    lzp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (q_out),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ----- sim/tb_lzp_predictor_encoder.sv -----
module tb_lzp_predictor_encoder;
    import lzp_pkg::*;

    localparam logic IN_DATA  = 1'b0;
    localparam logic IN_FLUSH = 1'b1;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 32;
    localparam int HOLD_CYCLES    = 2000;
    localparam int DRAIN_LIMIT    = 100000;
    localparam int TIMEOUT_CYCLES = 5000000;
    localparam int PHASE_ITEMS    = 100;

    localparam t_token NO_TOKEN = '0;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data;
        logic [16:0] count;    // number of consecutive words built from this row
        logic        ramp;     // data increments by one on each repetition
        logic        typed;    // tok is the expected result of the final repetition
        t_token      tok;
    } stim_row_t;

    localparam int N_ROWS = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;   // [0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [15:0] run_length, [23:16] literal_value
    logic [1:0]  m_axis_tuser;          // [1:0] token_kind
    logic        m_axis_tlast;

    // Encoder state as the testbench tracks it.
    logic [7:0]  guess_table [TABLE_DEPTH];
    logic [7:0]  lit_bytes [LITERAL_MAX];
    int unsigned ctx_hash;
    int unsigned match_len;
    int unsigned lit_len;
    logic [4:0]  hash_bits_now = HASH_BITS_RESET;

    t_token      new_tokens [$];
    t_token      tokens_due [$];

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_armed = 1'b0;
    int          error_count = 0;

    // Directed words. The first run of zero bytes keeps hitting the cleared
    // table and so builds a match run that the next byte closes.
    stim_row_t directed_rows [N_ROWS] = '{
        '{IN_FLUSH, 8'hFF, 17'd1,     1'b0, 1'b1, '{KIND_END,   16'd0,     8'd0, 1'b1}},
        '{IN_DATA,  8'h00, 17'd40,    1'b0, 1'b0, NO_TOKEN},
        '{IN_DATA,  8'hFF, 17'd1,     1'b0, 1'b0, NO_TOKEN},
        '{IN_DATA,  8'h00, 17'd1,     1'b0, 1'b0, NO_TOKEN},
        '{IN_DATA,  8'hA5, 17'd1,     1'b0, 1'b1, '{KIND_MATCH, 16'd1,     8'd0, 1'b1}},
        '{IN_DATA,  8'h01, 17'd61,    1'b1, 1'b0, NO_TOKEN},
        '{IN_DATA,  8'h80, 17'd1,     1'b0, 1'b0, NO_TOKEN},
        '{IN_FLUSH, 8'h5A, 17'd1,     1'b0, 1'b0, NO_TOKEN}
    };

    lzp_predictor_encoder uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic void clear_encoder();
        foreach (guess_table[i]) guess_table[i] = 8'h00;
        foreach (lit_bytes[i]) lit_bytes[i] = 8'h00;
        ctx_hash  = 0;
        match_len = 0;
        lit_len   = 0;
    endfunction

    function automatic void put_token(input logic [1:0] kind, input logic [15:0] len,
                                      input logic [7:0] value);
        t_token tok;
        tok.kind  = kind;
        tok.len   = len;
        tok.value = value;
        tok.last  = 1'b0;
        new_tokens.push_back(tok);
    endfunction

    function automatic void close_match_run();
        if (match_len != 0) begin
            put_token(KIND_MATCH, 16'(match_len), 8'h00);
            match_len = 0;
        end
    endfunction

    function automatic void close_literal_run();
        int i;
        if (lit_len != 0) begin
            put_token(KIND_LITHDR, 16'(lit_len), 8'h00);
            for (i = 0; i < lit_len; i++) put_token(KIND_LITBYTE, 16'h0000, lit_bytes[i]);
            lit_len = 0;
        end
    endfunction

    // Works out the tokens caused by one input word into new_tokens.
    function automatic void encode_word(input logic cmd, input logic [7:0] data);
        int unsigned width;
        int unsigned mask;
        int unsigned slot;
        new_tokens.delete();
        width = (hash_bits_now > TABLE_BITS) ? TABLE_BITS : hash_bits_now;
        mask  = (32'd1 << width) - 1;
        slot  = ctx_hash & mask;
        if (cmd == IN_FLUSH) begin
            close_match_run();
            close_literal_run();
            put_token(KIND_END, 16'h0000, 8'h00);
            clear_encoder();
        end else if (guess_table[slot] == data) begin
            close_literal_run();
            match_len++;
            if (match_len >= MATCH_MAX) close_match_run();
        end else begin
            close_match_run();
            if (lit_len < LITERAL_MAX) lit_bytes[lit_len] = data;
            lit_len++;
            guess_table[slot] = data;
            if (lit_len >= LITERAL_MAX) close_literal_run();
        end
        if (cmd != IN_FLUSH) ctx_hash = ((ctx_hash << HASH_SHIFT) + data) & mask;
        if (new_tokens.size() > 0) new_tokens[new_tokens.size() - 1].last = 1'b1;
    endfunction

    task automatic feed_word(input logic cmd, input logic [7:0] data, input bit typed,
                             input t_token tok);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        encode_word(cmd, data);
        if (typed)
            tokens_due.push_back(tok);
        else
            foreach (new_tokens[i]) tokens_due.push_back(new_tokens[i]);
    endtask

    task automatic wait_for_idle();
        s_axis_tvalid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge i_clk);
        // Data words may still be in flight without any token to show for it.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_hash_bits(input logic [4:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        hash_bits_now = value;
    endtask

    // Mostly repeated phrases and byte runs so that the predictions hit, with
    // noise in between; the stream is closed by a flush.
    task automatic run_random_stream(input int n_items);
        logic [7:0] phrase [$];
        logic [7:0] b;
        int sent;
        int r;
        int n;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                if (phrase.size() == 0 || $urandom_range(0, 3) == 0) begin
                    phrase.delete();
                    n = $urandom_range(2, 10);
                    repeat (n) begin
                        b = 8'($urandom_range(0, 255));
                        phrase.push_back(b);
                    end
                end
                n = $urandom_range(1, 4);
                repeat (n) begin
                    foreach (phrase[i]) feed_word(IN_DATA, phrase[i], 1'b0, NO_TOKEN);
                    sent += phrase.size();
                end
            end else if (r < 85) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    b = 8'($urandom_range(0, 255));
                    feed_word(IN_DATA, b, 1'b0, NO_TOKEN);
                end
                sent += n;
            end else begin
                b = 8'($urandom_range(0, 255));
                n = $urandom_range(1, 20);
                repeat (n) feed_word(IN_DATA, b, 1'b0, NO_TOKEN);
                sent += n;
            end
        end
        b = 8'($urandom_range(0, 255));
        feed_word(IN_FLUSH, b, 1'b0, NO_TOKEN);
    endtask

    // Receiver: checks each accepted word and decides tready for the next cycle.
    always @(posedge i_clk) begin : token_check
        t_token want;
        bit     hold_started;
        int     hold_left;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (tokens_due.size() == 0) begin
                $error("unexpected word: token_kind %0d run_length %0d literal_value %0d",
                       m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16]);
                error_count++;
            end else begin
                want = tokens_due.pop_front();
                if (m_axis_tuser !== want.kind) begin
                    $error("token_kind: expected %0d, got %0d", want.kind, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[15:0] !== want.len) begin
                    $error("run_length: expected %0d, got %0d", want.len, m_axis_tdata[15:0]);
                    error_count++;
                end
                if (m_axis_tdata[23:16] !== want.value) begin
                    $error("literal_value: expected %0d, got %0d", want.value,
                           m_axis_tdata[23:16]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
        // The long hold-off starts with the first word the block takes once armed,
        // so that it does not vanish into the table clear after a flush.
        if (hold_armed && !hold_started && s_axis_tvalid && s_axis_tready) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial begin : stimulus
        int rep;
        int waited;
        logic [7:0] data;
        clear_encoder();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_hash_bits(5'd16);

        foreach (directed_rows[r]) begin
            for (rep = 0; rep < directed_rows[r].count; rep++) begin
                data = directed_rows[r].ramp ? directed_rows[r].data + rep[7:0]
                                             : directed_rows[r].data;
                feed_word(directed_rows[r].cmd, data,
                          directed_rows[r].typed && rep == directed_rows[r].count - 1,
                          directed_rows[r].tok);
            end
        end

        // Above the table width, so the full 16 bits are used.
        wait_for_idle();
        write_hash_bits(5'd31);
        run_random_stream(PHASE_ITEMS);

        wait_for_idle();
        write_hash_bits(5'd8);
        send_idle_pct = 79;
        run_random_stream(PHASE_ITEMS);

        // A zero mask puts every byte on the same table entry.
        wait_for_idle();
        write_hash_bits(5'd0);
        send_idle_pct = 0;
        stall_pct     = 79;
        hold_armed    = 1'b1;
        run_random_stream(PHASE_ITEMS);

        wait_for_idle();
        write_hash_bits(5'd7);
        send_idle_pct = 28;
        stall_pct     = 28;
        run_random_stream(PHASE_ITEMS);

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (tokens_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tokens_due.size() != 0) begin
            $error("%0d expected words never arrived", tokens_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        repeat (TIMEOUT_CYCLES) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

endmodule
